### rtl/hvn_pkg.sv
// Package with shared types, constants and helper functions for the height grid normal unit.
`timescale 1ns / 1ps

package hvn_pkg;

    // Field widths fixed by the interface.
    localparam int HW   = 16;          // height sample, signed Q8.8
    localparam int CSW  = 16;          // cell size, unsigned Q8.8
    localparam int PW   = 22;          // position outputs
    localparam int NW   = 16;          // normal outputs, Q1.14
    localparam int GLW  = 7;           // grid level register
    localparam int XYW  = 7;           // column and row fields

    // Internal arithmetic widths.
    localparam int VW   = 21;          // signed accumulated vector component
    localparam int V2W  = 2 * VW;      // square of a component magnitude
    localparam int SW   = V2W + 2;     // sum of three squares
    localparam int QW   = 15;          // normal magnitude, 0..16384
    localparam int LW   = 2 * QW + SW + 2;
    localparam int VSH  = 30;          // the 2^30 scale of the comparison

    localparam logic [QW-1:0] ONE_Q14 = QW'(16384);

    // Configuration register indices.
    localparam logic CFG_GRID_LEVEL = 1'b0;
    localparam logic CFG_CELL_SIZE  = 1'b1;

    // Neighbour sample order used by the read sequence.
    localparam logic [2:0] NB_C  = 3'd0;
    localparam logic [2:0] NB_E  = 3'd1;
    localparam logic [2:0] NB_S  = 3'd2;
    localparam logic [2:0] NB_SE = 3'd3;
    localparam logic [2:0] NB_W  = 3'd4;
    localparam logic [2:0] NB_NW = 3'd5;
    localparam logic [2:0] NB_N  = 3'd6;

    // Weights of one sample in the summed cross product.
    typedef struct packed {
        logic signed [2:0] cx;
        logic signed [2:0] cz;
    } coef_t;

    // Start request to the normalising unit.
    typedef struct packed {
        logic start;
    } norm_ctl_t;

    // Status back from the normalising unit.
    typedef struct packed {
        logic busy;
        logic done;
    } norm_sts_t;

    // Weight of neighbour idx given which of the four surrounding cells exist:
    // a is cell (x,y), b is (x-1,y), c is (x-1,y-1), d is (x,y-1).
    function automatic coef_t nb_coef(input logic [2:0] idx, input logic a,
                                      input logic b, input logic c, input logic d);
        logic signed [2:0] sa;
        logic signed [2:0] sb;
        logic signed [2:0] sc;
        logic signed [2:0] sd;
        coef_t r;
        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        sd = $signed({2'b00, d});
        r  = '0;
        case (idx)
            NB_C:
            begin
                r.cx = sa - sb - sc + sd;
                r.cz = sa + sb - sc - sd;
            end
            NB_E:
            begin
                r.cx = -sa - sd;
                r.cz = sa;
            end
            NB_S:
            begin
                r.cx = sa;
                r.cz = -sa - sb;
            end
            NB_SE:
            begin
                r.cx = -sa;
                r.cz = -sa;
            end
            NB_W:
            begin
                r.cx = sb + sc;
                r.cz = -sc;
            end
            NB_NW:
            begin
                r.cx = sc;
                r.cz = sc;
            end
            NB_N:
            begin
                r.cx = -sc;
                r.cz = sc + sd;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Weighted sample: the weight is one of -2..2, so shifts and negation do.
    function automatic logic signed [VW-1:0] weigh(input logic signed [2:0] w,
                                                   input logic signed [HW-1:0] h);
        logic signed [VW-1:0] he;
        logic signed [VW-1:0] r;
        he = VW'(h);
        case (w)
            3'sd1:   r = he;
            -3'sd1:  r = -he;
            3'sd2:   r = he <<< 1;
            -3'sd2:  r = -(he <<< 1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/hvn_ram.sv
// Generic single write, single read RAM with a registered read port.
`timescale 1ns / 1ps

module hvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4225,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/hvn_norm.sv
// Bit-serial normalising unit: finds round(16384 * |v| / sqrt(s)) one result bit at a time.
`timescale 1ns / 1ps

module hvn_norm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hvn_pkg::norm_ctl_t    ctl,
    input  logic [hvn_pkg::SW-1:0]  s,
    input  logic [hvn_pkg::V2W-1:0] v2,
    output hvn_pkg::norm_sts_t    sts,
    output logic [hvn_pkg::QW-1:0]  q
);

    import hvn_pkg::*;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic [3:0]    b_reg, b_next;
    logic [QW-1:0] q_reg, q_next;
    logic [QW-1:0] qt_reg, qt_next;
    logic [LW-1:0] q1_reg, q1_next;
    logic [LW-1:0] q2_reg, q2_next;
    logic [LW-1:0] q1t_reg, q1t_next;
    logic [LW-1:0] q2t_reg, q2t_next;
    logic [LW-1:0] vv_reg, vv_next;
    logic [SW-1:0] s_reg, s_next;
    logic [LW-1:0] lhs;
    logic          ok;

    // The test (2q-1)^2 * s <= v^2 * 2^30, kept as 4*q^2*s - 4*q*s + s.
    assign lhs = (q2t_reg << 2) - (q1t_reg << 2) + LW'(s_reg);
    assign ok  = (qt_reg <= ONE_Q14) && (lhs <= vv_reg);

    // Each trial bit runs in two phases: form the trial sums, then compare.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        b_next     = b_reg;
        q_next     = q_reg;
        qt_next    = qt_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        q1t_next   = q1t_reg;
        q2t_next   = q2t_reg;
        vv_next    = vv_reg;
        s_next     = s_reg;
        if (ctl.start && !busy_reg)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            b_next     = 4'd14;
            q_next     = '0;
            q1_next    = '0;
            q2_next    = '0;
            s_next     = s;
            vv_next    = LW'(v2) << VSH;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                qt_next  = q_reg | (QW'(1) << b_reg);
                q1t_next = q1_reg + (LW'(s_reg) << b_reg);
                q2t_next = q2_reg + (q1_reg << ({1'b0, b_reg} + 5'd1))
                         + (LW'(s_reg) << {b_reg, 1'b0});
                phase_next = 1'b1;
            end
            else
            begin
                if (ok)
                begin
                    q_next  = qt_reg;
                    q1_next = q1t_reg;
                    q2_next = q2t_reg;
                end
                phase_next = 1'b0;
                if (b_reg == 4'd0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    b_next = b_reg - 4'd1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        q_reg   <= q_next;
        qt_reg  <= qt_next;
        q1_reg  <= q1_next;
        q2_reg  <= q2_next;
        q1t_reg <= q1t_next;
        q2t_reg <= q2t_next;
        vv_reg  <= vv_next;
        s_reg   <= s_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign q        = q_reg;

    // A finished magnitude never exceeds one in Q1.14.
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (q_reg <= ONE_Q14))
        else $error("normal magnitude above one");

    // A new request only arrives while the unit is free.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("start while busy");

endmodule

### rtl/heightmap_vertex_normal.sv
// Top level: height grid store, neighbour read sequencer and vertex normal output.
//
//  Channel | Handshake            | Carries
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | kind, column, row, height
//  output  | out_valid / out_stall| pos_x, pos_z, pos_y, normal_x/y/z, out_of_range
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load writes the store directly. A query stalls further items until done: reads
// through the single store read port, squaring of the three components, a run of the
// normalising unit per component unless the vector is zero (starting it, fifteen trial
// bits, collecting the result) and loading the output register, which waits while the
// output stalls; a query outside the grid goes straight to that load. Reset clears only
// control and configuration registers; the store holds nothing defined until written.
// A finished result waits in the output register while a further load is taken.
`timescale 1ns / 1ps

module heightmap_vertex_normal #(
    parameter int MAX_LEVEL = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [hvn_pkg::XYW-1:0]         column,
    input  logic [hvn_pkg::XYW-1:0]         row,
    input  logic signed [hvn_pkg::HW-1:0]   height,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hvn_pkg::PW-1:0]          pos_x,
    output logic [hvn_pkg::PW-1:0]          pos_z,
    output logic signed [hvn_pkg::HW-1:0]   pos_y,
    output logic signed [hvn_pkg::NW-1:0]   normal_x,
    output logic signed [hvn_pkg::NW-1:0]   normal_y,
    output logic signed [hvn_pkg::NW-1:0]   normal_z,
    output logic                            out_of_range,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [hvn_pkg::CSW-1:0]         cfg_data
);

    import hvn_pkg::*;

    localparam int STRIDE = MAX_LEVEL + 1;
    localparam int DEPTH  = STRIDE * STRIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CB     = $clog2(MAX_LEVEL + 2);
    localparam int CMPW   = ((CB > XYW) ? CB : XYW) + 2;
    localparam logic [AW-1:0]   STRIDE_A = AW'(STRIDE);
    localparam logic [CMPW-1:0] MAXL_C   = CMPW'(MAX_LEVEL);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SQ    = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_NWAIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           k_reg, k_next;
    logic [1:0]           j_reg, j_next;
    logic [GLW-1:0]       level_reg;
    logic [CSW-1:0]       cell_reg;
    logic [XYW-1:0]       x_reg, x_next;
    logic [XYW-1:0]       y_reg, y_next;
    logic                 fa_reg, fb_reg, fc_reg, fd_reg;
    logic                 fa_next, fb_next, fc_next, fd_next;
    logic                 oor_reg, oor_next;
    logic signed [VW-1:0] vx_reg, vx_next;
    logic signed [VW-1:0] vz_reg, vz_next;
    logic signed [VW-1:0] vy_reg, vy_next;
    logic signed [HW-1:0] hc_reg, hc_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [V2W-1:0]       sq_reg [3];
    logic [V2W-1:0]       sq_val;
    logic signed [NW-1:0] nrm_reg [3];
    logic signed [NW-1:0] nrm_val;
    logic                 sq_we, nrm_we, nrm_deg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [PW-1:0]        pos_x_reg, pos_z_reg;
    logic signed [HW-1:0] pos_y_reg;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 oor_out_reg;

    logic [CMPW-1:0]      lv_eff;
    logic [CMPW-1:0]      xc, yc;
    logic                 in_acc;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [HW-1:0]        rd_data;
    logic signed [CMPW-1:0] nc, nr;
    logic                 nb_ok;
    logic [2:0]           kp;
    coef_t                cw;
    logic signed [VW-1:0] vsel;
    logic [VW-1:0]        vmag;
    logic [2:0]           cnt;
    norm_ctl_t            nctl;
    norm_sts_t            nsts;
    logic [QW-1:0]        nq;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= GLW'(64);
            cell_reg  <= CSW'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_LEVEL: level_reg <= cfg_data[GLW-1:0];
                CFG_CELL_SIZE:  cell_reg  <= cfg_data;
                default:        cell_reg  <= cell_reg;
            endcase
        end
    end

    // Effective level: zero acts as one, anything above the store size is clipped.
    always_comb
    begin
        if (level_reg == '0)
        begin
            lv_eff = CMPW'(1);
        end
        else if (CMPW'(level_reg) > MAXL_C)
        begin
            lv_eff = MAXL_C;
        end
        else
        begin
            lv_eff = CMPW'(level_reg);
        end
    end

    assign xc       = CMPW'(column);
    assign yc       = CMPW'(row);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Loads go straight into the store when they fall inside it.
    assign wr_en   = in_acc && !kind && (xc <= MAXL_C) && (yc <= MAXL_C);
    assign wr_addr = AW'(AW'(row) * STRIDE_A + AW'(column));

    // Neighbour coordinates of the read issued this cycle.
    always_comb
    begin
        nc = $signed(CMPW'(x_reg));
        nr = $signed(CMPW'(y_reg));
        case (k_reg)
            NB_E:    nc = nc + CMPW'(1);
            NB_S:    nr = nr + CMPW'(1);
            NB_SE:
            begin
                nc = nc + CMPW'(1);
                nr = nr + CMPW'(1);
            end
            NB_W:    nc = nc - CMPW'(1);
            NB_NW:
            begin
                nc = nc - CMPW'(1);
                nr = nr - CMPW'(1);
            end
            NB_N:    nr = nr - CMPW'(1);
            default: nc = nc;
        endcase
    end

    assign nb_ok   = !nc[CMPW-1] && !nr[CMPW-1] && ($unsigned(nc) <= MAXL_C)
                   && ($unsigned(nr) <= MAXL_C);
    assign rd_en   = (state_reg == ST_READ) && (k_reg != 3'd7) && nb_ok;
    assign rd_addr = nb_ok ? AW'(AW'($unsigned(nr)) * STRIDE_A + AW'($unsigned(nc))) : '0;

    hvn_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (height),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Weight of the sample that arrives this cycle (read in the cycle before).
    assign kp  = k_reg - 3'd1;
    assign cw  = nb_coef(kp, fa_reg, fb_reg, fc_reg, fd_reg);
    assign cnt = 3'({fa_reg, 1'b0}) + 3'(fb_reg) + 3'({fc_reg, 1'b0}) + 3'(fd_reg);

    // Component picked for squaring and normalising.
    always_comb
    begin
        case (j_reg)
            2'd0:    vsel = vx_reg;
            2'd1:    vsel = vy_reg;
            default: vsel = vz_reg;
        endcase
    end
    assign vmag   = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
    assign sq_val = V2W'(vmag) * V2W'(vmag);
    assign nrm_val = vsel[VW-1] ? -$signed(NW'(nq)) : $signed(NW'(nq));

    // Query sequencer.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        fc_next    = fc_reg;
        fd_next    = fd_reg;
        oor_next   = oor_reg;
        vx_next    = vx_reg;
        vz_next    = vz_reg;
        vy_next    = vy_reg;
        hc_next    = hc_reg;
        s_next     = s_reg;
        sq_we      = 1'b0;
        nrm_we     = 1'b0;
        nrm_deg    = 1'b0;
        nctl.start = 1'b0;
        out_load   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && kind)
                begin
                    x_next   = column;
                    y_next   = row;
                    fa_next  = (xc < lv_eff) && (yc < lv_eff);
                    fb_next  = (xc != '0) && (yc < lv_eff);
                    fc_next  = (xc != '0) && (yc != '0);
                    fd_next  = (xc < lv_eff) && (yc != '0);
                    oor_next = (xc > lv_eff) || (yc > lv_eff);
                    vx_next  = '0;
                    vz_next  = '0;
                    s_next   = '0;
                    k_next   = '0;
                    state_next = ((xc > lv_eff) || (yc > lv_eff)) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_reg != 3'd0)
                begin
                    vx_next = vx_reg + weigh(cw.cx, $signed(rd_data));
                    vz_next = vz_reg + weigh(cw.cz, $signed(rd_data));
                    if (kp == NB_C)
                    begin
                        hc_next = $signed(rd_data);
                    end
                end
                if (k_reg == 3'd7)
                begin
                    vy_next    = $signed(VW'(cnt * {3'b000, cell_reg}));
                    j_next     = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_SQ:
            begin
                sq_we  = 1'b1;
                s_next = s_reg + SW'(sq_val);
                if (j_reg == 2'd2)
                begin
                    j_next     = '0;
                    state_next = ST_NORM;
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            ST_NORM:
            begin
                if (s_reg == '0)
                begin
                    nrm_deg    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    nctl.start = 1'b1;
                    state_next = ST_NWAIT;
                end
            end
            ST_NWAIT:
            begin
                if (nsts.done)
                begin
                    nrm_we = 1'b1;
                    if (j_reg == 2'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    hvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nctl),
        .s     (s_reg),
        .v2    (sq_reg[j_reg]),
        .sts   (nsts),
        .q     (nq)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current query.
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        j_reg   <= j_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        fa_reg  <= fa_next;
        fb_reg  <= fb_next;
        fc_reg  <= fc_next;
        fd_reg  <= fd_next;
        oor_reg <= oor_next;
        vx_reg  <= vx_next;
        vz_reg  <= vz_next;
        vy_reg  <= vy_next;
        hc_reg  <= hc_next;
        s_reg   <= s_next;
        if (sq_we)
        begin
            sq_reg[j_reg] <= sq_val;
        end
        if (nrm_deg)
        begin
            nrm_reg[0] <= '0;
            nrm_reg[1] <= $signed(NW'(ONE_Q14));
            nrm_reg[2] <= '0;
        end
        else if (nrm_we)
        begin
            nrm_reg[j_reg] <= nrm_val;
        end
    end

    // Output register; a query outside the grid carries only its flag.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg   <= oor_reg ? '0 : PW'(x_reg * cell_reg);
            pos_z_reg   <= oor_reg ? '0 : PW'(y_reg * cell_reg);
            pos_y_reg   <= oor_reg ? '0 : hc_reg;
            nx_reg      <= oor_reg ? '0 : nrm_reg[0];
            ny_reg      <= oor_reg ? '0 : nrm_reg[1];
            nz_reg      <= oor_reg ? '0 : nrm_reg[2];
            oor_out_reg <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_z        = pos_z_reg;
    assign pos_y        = pos_y_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign out_of_range = oor_out_reg;

    // A result outside the grid carries no normal.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("normal set on out-of-range result");

    // A query always starts the sequencer.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind) |=> (state_reg != ST_IDLE))
        else $error("query did not start the sequencer");

    // The normalising unit only reports back while it is being waited on.
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        nsts.done |-> (state_reg == ST_NWAIT))
        else $error("normaliser finished outside its wait state");

    // The normaliser is only started from its issue state.
    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        nctl.start |-> (state_reg == ST_NORM && s_reg != '0))
        else $error("normaliser started out of sequence");

endmodule

### tb/heightmap_vertex_normal_tb.sv
// Testbench for the height grid vertex normal unit, with a scoreboard that predicts every query.
`timescale 1ns / 1ps

module heightmap_vertex_normal_tb;

    import hvn_pkg::*;

    localparam int MAXL     = 64;
    localparam int STRIDE   = MAXL + 1;
    localparam int WD_LIMIT = 5000;
    localparam int SETTLE   = 150;

    // One result of a query, in the block's own widths.
    typedef struct packed {
        logic [PW-1:0]        px;
        logic [PW-1:0]        pz;
        logic signed [HW-1:0] py;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic                 oor;
    } vtx_result_t;

    // Keeps a copy of the grid and the registers and predicts each query result.
    class vertex_scoreboard;
        logic signed [HW-1:0] heights [STRIDE*STRIDE];
        bit                   written [STRIDE*STRIDE];
        int unsigned          level;
        int unsigned          spacing;
        vtx_result_t          awaited [$];
        int                   mismatches;

        function new();
            level      = 64;
            spacing    = 256;
            mismatches = 0;
            foreach (heights[i])
                heights[i] = '0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function void write_reg(logic idx, int unsigned value);
            if (idx == CFG_GRID_LEVEL)
                level = value & 'h7F;
            else
                spacing = value & 'hFFFF;
        endfunction

        function int grid_limit();
            if (level < 1)
                return 1;
            if (level > MAXL)
                return MAXL;
            return level;
        endfunction

        // True for a point inside the grid whose sample has not been written yet.
        function bit needs_load(int c, int r, int lv);
            if (c < 0 || r < 0 || c > lv || r > lv)
                return 1'b0;
            return !written[r * STRIDE + c];
        endfunction

        function int h(int c, int r);
            return heights[r * STRIDE + c];
        endfunction

        // Largest q with (2q-1)^2 * total <= mag^2 * 2^30, which rounds half away from zero.
        function int unsigned unit_mag(int unsigned mag, logic [127:0] total);
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            logic [127:0] odd;
            logic [127:0] rhs;
            lo  = 0;
            hi  = 16384;
            rhs = (128'(mag) * 128'(mag)) << 30;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                odd = 128'(2 * mid - 1);
                if (odd * odd * total <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function logic signed [NW-1:0] signed_unit(longint v, logic [127:0] total);
            int unsigned m;
            m = unit_mag(v < 0 ? -v : v, total);
            return v < 0 ? -NW'(m) : NW'(m);
        endfunction

        // Notes an accepted item: a load updates the grid, a query queues its result.
        function void note_input(bit kind, int c, int r, int hv);
            int           lv;
            longint       vx;
            longint       vz;
            longint       vy;
            int           tris;
            logic [127:0] total;
            vtx_result_t  e;
            if (kind == 1'b0)
            begin
                if (c <= MAXL && r <= MAXL)
                begin
                    heights[r * STRIDE + c] = hv[HW-1:0];
                    written[r * STRIDE + c] = 1'b1;
                end
                return;
            end
            e  = '0;
            lv = grid_limit();
            if (c > lv || r > lv)
            begin
                e.oor = 1'b1;
                awaited.push_back(e);
                return;
            end
            vx   = 0;
            vz   = 0;
            tris = 0;
            // Both triangles of the cell to the south-east.
            if (c < lv && r < lv)
            begin
                vx += h(c, r) - h(c+1, r) + h(c, r+1) - h(c+1, r+1);
                vz += h(c+1, r) - h(c+1, r+1) + h(c, r) - h(c, r+1);
                tris += 2;
            end
            // Upper triangle of the cell to the west.
            if (c >= 1 && r < lv)
            begin
                vx += h(c-1, r) - h(c, r);
                vz += h(c, r) - h(c, r+1);
                tris += 1;
            end
            // Both triangles of the cell to the north-west.
            if (c >= 1 && r >= 1)
            begin
                vx += h(c-1, r-1) - h(c, r-1) + h(c-1, r) - h(c, r);
                vz += h(c, r-1) - h(c, r) + h(c-1, r-1) - h(c-1, r);
                tris += 2;
            end
            // Lower triangle of the cell to the north.
            if (c < lv && r >= 1)
            begin
                vx += h(c, r) - h(c+1, r);
                vz += h(c, r-1) - h(c, r);
                tris += 1;
            end
            vy    = longint'(tris) * spacing;
            total = 128'(vx * vx) + 128'(vy * vy) + 128'(vz * vz);
            if (total == 0)
            begin
                e.ny = NW'(16384);
            end
            else
            begin
                e.nx = signed_unit(vx, total);
                e.ny = signed_unit(vy, total);
                e.nz = signed_unit(vz, total);
            end
            e.px = PW'(longint'(c) * spacing);
            e.pz = PW'(longint'(r) * spacing);
            e.py = heights[r * STRIDE + c];
            awaited.push_back(e);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(vtx_result_t got);
            vtx_result_t e;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing awaited: %p", $realtime, got);
                return;
            end
            e = awaited.pop_front();
            if (got.px !== e.px || got.pz !== e.pz || got.py !== e.py || got.nx !== e.nx
                || got.ny !== e.ny || got.nz !== e.nz || got.oor !== e.oor)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch\n  expected %p\n  actual   %p", $realtime, e, got);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [XYW-1:0]        column;
    logic [XYW-1:0]        row;
    logic signed [HW-1:0]  height;
    logic                  out_valid;
    logic                  out_stall;
    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         pos_z;
    logic signed [HW-1:0]  pos_y;
    logic signed [NW-1:0]  normal_x;
    logic signed [NW-1:0]  normal_y;
    logic signed [NW-1:0]  normal_z;
    logic                  out_of_range;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CSW-1:0]        cfg_data;

    vertex_scoreboard sb;
    bit               quiet;
    int               idle_cycles;
    int               stall_left;

    heightmap_vertex_normal #(.MAX_LEVEL(MAXL)) dut (.*);

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 6) == 0)
        begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 4);
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Result checking and the watchdog.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({pos_x, pos_z, pos_y, normal_x, normal_y, normal_z, out_of_range});
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Sends one item, with an occasional gap in front of it.
    task automatic send_item(bit k, int c, int r, int hv);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        kind     = k;
        column   = c[XYW-1:0];
        row      = r[XYW-1:0];
        height   = hv[HW-1:0];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(k, c, r, hv);
    endtask

    // Holds the sender until every awaited result has come and the block is idle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value[CSW-1:0];
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int rand_height();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 64) - 32;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // Coordinates cluster near both edges and the middle, so few samples need writing.
    function automatic int rand_coord();
        int lv;
        lv = sb.grid_limit();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 127);
            1, 2, 3: return $urandom_range(0, (lv < 3) ? lv : 3);
            4, 5, 6: return $urandom_range((lv < 3) ? 0 : lv - 3, lv);
            default: return lv / 2 + $urandom_range(0, 1);
        endcase
    endfunction

    // Writes any unwritten sample around a point inside the grid, then queries it.
    task automatic send_query(int c, int r);
        int lv;
        lv = sb.grid_limit();
        if (c <= lv && r <= lv)
        begin
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    if (sb.needs_load(c + dc, r + dr, lv))
                        send_item(1'b0, c + dc, r + dr, rand_height());
                end
            end
        end
        send_item(1'b1, c, r, int'($urandom));
    endtask

    // One phase of random traffic under fixed register values.
    task automatic random_phase(int unsigned lvl, int unsigned spc, int count);
        write_reg(CFG_GRID_LEVEL, lvl);
        write_reg(CFG_CELL_SIZE, spc);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                send_item(1'b0, rand_coord(), rand_coord(), rand_height());
            else
                send_query(rand_coord(), rand_coord());
        end
        drain();
    endtask

    initial
    begin
        sb         = new();
        quiet      = 1'b0;
        idle_cycles = 0;
        stall_left = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = 1'b0;
        column     = '0;
        row        = '0;
        height     = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_GRID_LEVEL;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset register values.
        send_query(0, 0);
        send_query(MAXL, 0);
        send_query(0, MAXL);
        send_query(MAXL, MAXL);
        send_query(31, 17);
        send_query(0, 40);
        send_query(22, MAXL);
        send_query(MAXL + 1, 0);
        send_query(127, 127);
        send_item(1'b0, 127, 5, 1234);
        send_item(1'b0, 5, 100, -1234);
        send_item(1'b0, 3, 3, -32768);
        send_item(1'b0, 4, 4, 32767);
        send_query(3, 3);
        send_query(4, 3);
        drain();

        // A flat patch with zero spacing gives the upright default normal.
        write_reg(CFG_CELL_SIZE, 0);
        for (int r = 9; r <= 11; r++)
            for (int c = 9; c <= 11; c++)
                send_item(1'b0, c, r, 77);
        send_query(10, 10);
        drain();

        // Level zero behaves as one, and a level above the maximum as the maximum.
        write_reg(CFG_GRID_LEVEL, 0);
        write_reg(CFG_CELL_SIZE, 65535);
        send_query(1, 1);
        send_query(2, 0);
        send_item(1'b0, 60, 60, 500);
        drain();
        write_reg(CFG_GRID_LEVEL, 127);
        send_query(MAXL, MAXL);
        send_query(MAXL, MAXL + 1);
        drain();

        // Random phases over several register settings.
        random_phase(64, 256, 200);
        random_phase(1, 1, 100);
        random_phase(0, 65535, 100);
        random_phase(127, 0, 100);
        random_phase($urandom_range(2, 63), $urandom_range(1, 65535), 200);
        random_phase(7, $urandom_range(1, 1024), 150);
        quiet = 1'b1;
        random_phase(64, 65535, 200);

        drain();
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
